>>> rtl/core/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg - shared types and constants for the midpoint line rasterizer
// Coordinate and decision widths, action codes, slope classes and the
// per-line state record passed between setup, step and top level.
// ----------------------------------------------------------------------------
package mlr_pkg;

    localparam int COORD_BITS = 16;
    // Coordinate difference plus one bit of headroom for negation and sums.
    localparam int DEC_BITS   = COORD_BITS + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DEC_BITS-1:0]   dec_t;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } action_t;

    // Octant-style slope classes; major axis always steps by one.
    typedef enum logic [1:0] {
        CLS_SHALLOW_UP   = 2'd0,   // 0 < dy < dx : major x+, minor y+
        CLS_STEEP_UP     = 2'd1,   // dy > dx     : major y+, minor x+
        CLS_SHALLOW_DOWN = 2'd2,   // -dx < dy < 0: major x+, minor y-
        CLS_STEEP_DOWN   = 2'd3    // dy < -dx    : major y-, minor x+
    } slope_class_t;

    typedef struct packed {
        coord_t       cur_x;
        coord_t       cur_y;
        dec_t         decision_acc;
        coord_t       major_end;
        dec_t         straight_inc;
        dec_t         diagonal_inc;
        slope_class_t slope_class;
    } line_state_t;

endpackage

>>> rtl/core/mlr_setup.sv
// ----------------------------------------------------------------------------
// mlr_setup - line classification
// Derives slope class, initial decision value and increments from the two
// endpoints; flags degenerate lines that draw nothing.
// ----------------------------------------------------------------------------
module mlr_setup (
    input  mlr_pkg::coord_t      start_x,
    input  mlr_pkg::coord_t      start_y,
    input  mlr_pkg::coord_t      end_x,
    input  mlr_pkg::coord_t      end_y,
    output logic                 draw,
    output mlr_pkg::line_state_t init
);

    localparam int CB = mlr_pkg::COORD_BITS;
    localparam int DW = mlr_pkg::DEC_BITS;

    logic signed [DW-1:0] dxw;
    logic signed [DW-1:0] dyw;
    logic signed [DW-1:0] ndxw;
    logic signed [DW-1:0] ndyw;
    logic signed [DW-1:0] dx_half;
    logic signed [DW-1:0] dy_half;

    always_comb
    begin
        dxw  = $signed({{2{end_x[CB-1]}}, end_x}) - $signed({{2{start_x[CB-1]}}, start_x});
        dyw  = $signed({{2{end_y[CB-1]}}, end_y}) - $signed({{2{start_y[CB-1]}}, start_y});
        ndxw = -dxw;
        ndyw = -dyw;
        // dx is non-negative wherever its half is used
        dx_half = dxw >>> 1;
        // truncation toward zero for a negative dy
        dy_half = $signed(dyw + DW'(dyw[DW-1])) >>> 1;

        draw = !(dxw[DW-1] || (dyw == '0) || (dyw == dxw) || (dyw == ndxw));

        init.cur_x = start_x;
        init.cur_y = start_y;

        if (!dyw[DW-1] && (dyw != '0) && (dyw < dxw))
        begin
            init.slope_class  = mlr_pkg::CLS_SHALLOW_UP;
            init.decision_acc = dyw - dx_half;
            init.straight_inc = dyw;
            init.diagonal_inc = dyw - dxw;
            init.major_end    = end_x;
        end
        else if (dyw > dxw)
        begin
            init.slope_class  = mlr_pkg::CLS_STEEP_UP;
            init.decision_acc = dxw - dy_half;
            init.straight_inc = dxw;
            init.diagonal_inc = dxw - dyw;
            init.major_end    = end_y;
        end
        else if (dyw[DW-1] && (dyw > ndxw))
        begin
            init.slope_class  = mlr_pkg::CLS_SHALLOW_DOWN;
            init.decision_acc = ndyw - dx_half;
            init.straight_inc = ndyw;
            init.diagonal_inc = ndyw - dxw;
            init.major_end    = end_x;
        end
        else
        begin
            init.slope_class  = mlr_pkg::CLS_STEEP_DOWN;
            init.decision_acc = dxw + dy_half;
            init.straight_inc = dxw;
            init.diagonal_inc = dxw + dyw;
            init.major_end    = end_y;
        end
    end

endmodule

>>> rtl/core/mlr_step.sv
// ----------------------------------------------------------------------------
// mlr_step - point emission and advance
// Emits the current point with its decision value and end flag, and forms
// the line state for the following point.
// ----------------------------------------------------------------------------
module mlr_step (
    input  mlr_pkg::line_state_t cur,
    output mlr_pkg::coord_t      point_x,
    output mlr_pkg::coord_t      point_y,
    output mlr_pkg::dec_t        decision,
    output logic                 last_point,
    output mlr_pkg::line_state_t nxt
);

    localparam int DW = mlr_pkg::DEC_BITS;

    logic            minor_moves;
    mlr_pkg::coord_t major;

    always_comb
    begin
        minor_moves = !cur.decision_acc[DW-1];
        major = (cur.slope_class inside {mlr_pkg::CLS_SHALLOW_UP, mlr_pkg::CLS_SHALLOW_DOWN})
                ? cur.cur_x : cur.cur_y;

        point_x    = cur.cur_x;
        point_y    = cur.cur_y;
        decision   = cur.decision_acc;
        last_point = (major == cur.major_end);

        nxt = cur;
        nxt.decision_acc = cur.decision_acc
                         + (minor_moves ? cur.diagonal_inc : cur.straight_inc);
        case (cur.slope_class)
            mlr_pkg::CLS_SHALLOW_UP:
            begin
                nxt.cur_x = cur.cur_x + 1'b1;
                if (minor_moves) nxt.cur_y = cur.cur_y + 1'b1;
            end
            mlr_pkg::CLS_STEEP_UP:
            begin
                nxt.cur_y = cur.cur_y + 1'b1;
                if (minor_moves) nxt.cur_x = cur.cur_x + 1'b1;
            end
            mlr_pkg::CLS_SHALLOW_DOWN:
            begin
                nxt.cur_x = cur.cur_x + 1'b1;
                if (minor_moves) nxt.cur_y = cur.cur_y - 1'b1;
            end
            default:
            begin
                nxt.cur_y = cur.cur_y - 1'b1;
                if (minor_moves) nxt.cur_x = cur.cur_x + 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/core/midpoint_line_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer - integer midpoint line drawing
// Start transactions load a line and emit its first point; step
// transactions emit each following point until the end point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries action plus four endpoint
//   coordinates. action = start classifies the line and emits its first
//   point; action = step emits the next point of the active line. The
//   endpoints are only looked at on a start.
//   Output channel (out_valid/out_ready) carries point_x, point_y, the
//   decision value of that point and last_point, set on the end point.
//   A degenerate start (dx < 0, dy = 0 or |dy| = dx) and a step with no
//   active line produce no output transaction. A start drops any line
//   still in progress.
//   Pipeline: two register stages (input register, then result register);
//   an accepted input waits in the input register until the result
//   register can take it. Throughput: one transaction per cycle while
//   out_ready stays high; the limit is the single add and compare on the
//   running decision value, which loops back into the line state register.
//   A result waiting in the output register does not block acceptance of
//   the next input; only when both registers are full and out_ready is
//   low does in_ready drop.
//   Reset (rst_n low, asynchronous) empties both registers and leaves no
//   line active.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            action,
    input  mlr_pkg::coord_t start_x,
    input  mlr_pkg::coord_t start_y,
    input  mlr_pkg::coord_t end_x,
    input  mlr_pkg::coord_t end_y,
    output logic            out_valid,
    input  logic            out_ready,
    output mlr_pkg::coord_t point_x,
    output mlr_pkg::coord_t point_y,
    output mlr_pkg::dec_t   decision,
    output logic            last_point
);

    // Input register stage
    logic                 in_valid_reg;
    logic                 action_reg;
    mlr_pkg::coord_t      start_x_reg;
    mlr_pkg::coord_t      start_y_reg;
    mlr_pkg::coord_t      end_x_reg;
    mlr_pkg::coord_t      end_y_reg;

    // Line state
    mlr_pkg::line_state_t line_reg;
    mlr_pkg::line_state_t line_next;
    logic                 active_reg;
    logic                 active_next;

    // Result register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    mlr_pkg::coord_t      point_x_reg;
    mlr_pkg::coord_t      point_y_reg;
    mlr_pkg::dec_t        decision_reg;
    logic                 last_reg;

    logic                 proc_fire;
    logic                 is_start;
    logic                 setup_draw;
    logic                 emit;
    mlr_pkg::line_state_t setup_line;
    mlr_pkg::line_state_t eff_line;
    mlr_pkg::line_state_t step_line;
    mlr_pkg::coord_t      step_x;
    mlr_pkg::coord_t      step_y;
    mlr_pkg::dec_t        step_dec;
    logic                 step_last;

    mlr_setup u_setup (
        .start_x (start_x_reg),
        .start_y (start_y_reg),
        .end_x   (end_x_reg),
        .end_y   (end_y_reg),
        .draw    (setup_draw),
        .init    (setup_line)
    );

    mlr_step u_step (
        .cur        (eff_line),
        .point_x    (step_x),
        .point_y    (step_y),
        .decision   (step_dec),
        .last_point (step_last),
        .nxt        (step_line)
    );

    // The held item is processed whenever the result register can take it.
    assign proc_fire = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || proc_fire;

    assign is_start = (action_reg == mlr_pkg::ACT_START);
    assign eff_line = is_start ? setup_line : line_reg;
    assign emit     = is_start ? setup_draw : active_reg;

    always_comb
    begin
        line_next      = line_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (proc_fire)
        begin
            if (emit)
            begin
                line_next      = step_line;
                active_next    = !step_last;
                out_valid_next = 1'b1;
            end
            else if (is_start)
            begin
                // degenerate line: nothing drawn, nothing active
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            line_reg      <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            line_reg      <= line_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg  <= action;
            start_x_reg <= start_x;
            start_y_reg <= start_y;
            end_x_reg   <= end_x;
            end_y_reg   <= end_y;
        end
        if (proc_fire && emit)
        begin
            point_x_reg  <= step_x;
            point_y_reg  <= step_y;
            decision_reg <= step_dec;
            last_reg     <= step_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign point_x    = point_x_reg;
    assign point_y    = point_y_reg;
    assign decision   = decision_reg;
    assign last_point = last_reg;

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the midpoint line rasterizer
// Drives start and step transactions (directed corners, then random lines,
// degenerate starts and noise), predicts every raster point in a tracker
// class and compares each output transaction field by field, in order.
// ----------------------------------------------------------------------------
module tb;

    // One expected raster point, as it should leave the output channel.
    typedef struct {
        mlr_pkg::coord_t x;
        mlr_pkg::coord_t y;
        mlr_pkg::dec_t   dec;
        logic            last;
    } raster_point_t;

    // ------------------------------------------------------------------------
    // Line tracker: shadow copy of the active line plus the queue of points
    // still owed by the block. Accepted inputs advance the shadow line;
    // accepted outputs are checked against the oldest owed point.
    // ------------------------------------------------------------------------
    class line_tracker;
        raster_point_t         pending_points[$];
        int                    mismatch_count;
        mlr_pkg::coord_t       cur_x;
        mlr_pkg::coord_t       cur_y;
        mlr_pkg::coord_t       major_end;
        mlr_pkg::dec_t         acc;
        mlr_pkg::dec_t         straight_inc;
        mlr_pkg::dec_t         diagonal_inc;
        mlr_pkg::slope_class_t cls;
        bit                    active;

        function new();
            mismatch_count = 0;
            cur_x          = '0;
            cur_y          = '0;
            major_end      = '0;
            acc            = '0;
            straight_inc   = '0;
            diagonal_inc   = '0;
            cls            = mlr_pkg::CLS_SHALLOW_UP;
            active         = 1'b0;
        endfunction

        function int pending();
            return pending_points.size();
        endfunction

        // Owe the current point, then take one midpoint step.
        function void trace_point();
            raster_point_t   pt;
            bit              moves;
            mlr_pkg::coord_t major;
            moves   = !acc[mlr_pkg::DEC_BITS-1];
            major   = (cls == mlr_pkg::CLS_SHALLOW_UP || cls == mlr_pkg::CLS_SHALLOW_DOWN)
                      ? cur_x : cur_y;
            pt.x    = cur_x;
            pt.y    = cur_y;
            pt.dec  = acc;
            pt.last = (major == major_end);
            pending_points.push_back(pt);
            acc += moves ? diagonal_inc : straight_inc;
            case (cls)
                mlr_pkg::CLS_SHALLOW_UP:
                begin
                    cur_x++;
                    if (moves) cur_y++;
                end
                mlr_pkg::CLS_STEEP_UP:
                begin
                    cur_y++;
                    if (moves) cur_x++;
                end
                mlr_pkg::CLS_SHALLOW_DOWN:
                begin
                    cur_x++;
                    if (moves) cur_y--;
                end
                default:
                begin
                    cur_y--;
                    if (moves) cur_x++;
                end
            endcase
            active = !pt.last;
        endfunction

        // Returns 0 only for a step that the block ignores (no line active).
        function bit accept_input(mlr_pkg::action_t act,
                                  mlr_pkg::coord_t sx, mlr_pkg::coord_t sy,
                                  mlr_pkg::coord_t ex, mlr_pkg::coord_t ey);
            int dx;
            int dy;
            if (act == mlr_pkg::ACT_STEP)
            begin
                if (!active) return 1'b0;
                trace_point();
                return 1'b1;
            end
            active = 1'b0;
            dx = int'(ex) - int'(sx);
            dy = int'(ey) - int'(sy);
            // backwards, horizontal, or exact diagonal: nothing drawn
            if (dx < 0 || dy == 0 || dy == dx || dy == -dx) return 1'b1;
            if (dy > 0 && dy < dx)
            begin
                cls          = mlr_pkg::CLS_SHALLOW_UP;
                acc          = mlr_pkg::dec_t'(dy - dx / 2);
                straight_inc = mlr_pkg::dec_t'(dy);
                diagonal_inc = mlr_pkg::dec_t'(dy - dx);
                major_end    = ex;
            end
            else if (dy > dx)
            begin
                cls          = mlr_pkg::CLS_STEEP_UP;
                acc          = mlr_pkg::dec_t'(dx - dy / 2);
                straight_inc = mlr_pkg::dec_t'(dx);
                diagonal_inc = mlr_pkg::dec_t'(dx - dy);
                major_end    = ey;
            end
            else if (dy < 0 && dy > -dx)
            begin
                cls          = mlr_pkg::CLS_SHALLOW_DOWN;
                acc          = mlr_pkg::dec_t'(-dy - dx / 2);
                straight_inc = mlr_pkg::dec_t'(-dy);
                diagonal_inc = mlr_pkg::dec_t'(-dy - dx);
                major_end    = ex;
            end
            else
            begin
                cls          = mlr_pkg::CLS_STEEP_DOWN;
                acc          = mlr_pkg::dec_t'(dx + dy / 2);
                straight_inc = mlr_pkg::dec_t'(dx);
                diagonal_inc = mlr_pkg::dec_t'(dx + dy);
                major_end    = ey;
            end
            cur_x = sx;
            cur_y = sy;
            trace_point();
            return 1'b1;
        endfunction

        task flag_mismatch(string msg);
            $display("mismatch @%0t: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_point(mlr_pkg::coord_t px, mlr_pkg::coord_t py,
                         mlr_pkg::dec_t dec, logic last);
            raster_point_t want;
            if (pending_points.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected point (%0d,%0d)", px, py));
                return;
            end
            want = pending_points.pop_front();
            if (px !== want.x)
                flag_mismatch($sformatf("point_x %0d, want %0d", px, want.x));
            if (py !== want.y)
                flag_mismatch($sformatf("point_y %0d, want %0d", py, want.y));
            if (dec !== want.dec)
                flag_mismatch($sformatf("decision %0d, want %0d", dec, want.dec));
            if (last !== want.last)
                flag_mismatch($sformatf("last_point %0b, want %0b at (%0d,%0d)",
                                        last, want.last, want.x, want.y));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic             action;
    mlr_pkg::coord_t  start_x;
    mlr_pkg::coord_t  start_y;
    mlr_pkg::coord_t  end_x;
    mlr_pkg::coord_t  end_y;
    logic             out_valid;
    logic             out_ready;
    mlr_pkg::coord_t  point_x;
    mlr_pkg::coord_t  point_y;
    mlr_pkg::dec_t    decision;
    logic             last_point;

    line_tracker tracker;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          fed_items;

    midpoint_line_rasterizer uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .decision   (decision),
        .last_point (last_point)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs or withholds a result.
    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: check every accepted point, then redraw out_ready.
    // Sampling happens on the edge, so values are the pre-edge ones.
    // ------------------------------------------------------------------------
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                tracker.check_point(point_x, point_y, decision, last_point);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Input side. Random idle cycles go before valid rises; once up, valid
    // and payload hold until the edge that accepts the transaction. Valid
    // then stays up until the next call or drain() assigns it.
    // ------------------------------------------------------------------------
    task automatic send_item(mlr_pkg::action_t act,
                             mlr_pkg::coord_t sx, mlr_pkg::coord_t sy,
                             mlr_pkg::coord_t ex, mlr_pkg::coord_t ey);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (tracker.accept_input(act, sx, sy, ex, ey)) fed_items++;
    endtask

    // Step transaction; endpoint fields are don't-care, so randomize them.
    task automatic send_step();
        send_item(mlr_pkg::ACT_STEP,
                  mlr_pkg::coord_t'($urandom), mlr_pkg::coord_t'($urandom),
                  mlr_pkg::coord_t'($urandom), mlr_pkg::coord_t'($urandom));
    endtask

    // Hold the input off until every owed point is out, plus pipeline slack.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Well-formed line: start, walk it to the end (sometimes cut short,
    // sometimes with a few dead steps after the end point).
    task automatic run_line();
        mlr_pkg::coord_t       sx;
        mlr_pkg::coord_t       sy;
        int                    span;
        int                    dx;
        int                    dy;
        int                    steps;
        mlr_pkg::slope_class_t cls;
        span = ($urandom_range(11) == 0) ? $urandom_range(40, 250) : $urandom_range(1, 16);
        cls  = mlr_pkg::slope_class_t'($urandom_range(3));
        case (cls)
            mlr_pkg::CLS_SHALLOW_UP:
            begin
                dx = span + 1;
                dy = $urandom_range(1, span);
            end
            mlr_pkg::CLS_STEEP_UP:
            begin
                dy = span + 1;
                dx = $urandom_range(0, span);
            end
            mlr_pkg::CLS_SHALLOW_DOWN:
            begin
                dx = span + 1;
                dy = -int'($urandom_range(1, span));
            end
            default:
            begin
                dy = -(span + 1);
                dx = $urandom_range(0, span);
            end
        endcase
        sx = mlr_pkg::coord_t'($urandom);
        sy = mlr_pkg::coord_t'($urandom);
        // keep the end point inside the coordinate range
        if (int'(sx) + dx > 32767) sx = mlr_pkg::coord_t'(int'(sx) - dx);
        if (int'(sy) + dy > 32767 || int'(sy) + dy < -32768)
            sy = mlr_pkg::coord_t'(int'(sy) - dy);
        send_item(mlr_pkg::ACT_START, sx, sy,
                  mlr_pkg::coord_t'(int'(sx) + dx), mlr_pkg::coord_t'(int'(sy) + dy));
        if ($urandom_range(9) == 0)
            steps = $urandom_range(0, span);
        else
            steps = span + 1 + $urandom_range(0, 2);
        repeat (steps) send_step();
    endtask

    // Start that must draw nothing, maybe followed by a dead step.
    task automatic degenerate_start();
        mlr_pkg::coord_t sx;
        mlr_pkg::coord_t sy;
        int              dx;
        int              dy;
        sx = mlr_pkg::coord_t'($urandom_range(0, 65535 - 600) - 32768 + 300);
        sy = mlr_pkg::coord_t'($urandom_range(0, 65535 - 600) - 32768 + 300);
        case ($urandom_range(2))
            0:
            begin
                dx = -int'($urandom_range(1, 300));
                dy = int'($urandom_range(0, 600)) - 300;
            end
            1:
            begin
                dx = $urandom_range(0, 300);
                dy = 0;
            end
            default:
            begin
                dx = $urandom_range(0, 300);
                dy = $urandom_range(1) ? dx : -dx;
            end
        endcase
        send_item(mlr_pkg::ACT_START, sx, sy,
                  mlr_pkg::coord_t'(int'(sx) + dx), mlr_pkg::coord_t'(int'(sy) + dy));
        if ($urandom_range(1)) send_step();
    endtask

    task automatic random_sequence();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            run_line();
        else if (pick < 85)
            degenerate_start();
        else
            send_item(mlr_pkg::action_t'($urandom_range(1)),
                      mlr_pkg::coord_t'($urandom), mlr_pkg::coord_t'($urandom),
                      mlr_pkg::coord_t'($urandom), mlr_pkg::coord_t'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int target;
        tracker       = new();
        fed_items     = 0;
        send_idle_pct = 31;
        recv_idle_pct = 65;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        action       <= mlr_pkg::ACT_START;
        start_x      <= '0;
        start_y      <= '0;
        end_x        <= '0;
        end_y        <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners.
        send_step();                                           // no line yet
        // dy == dx
        send_item(mlr_pkg::ACT_START, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        // widest shallow
        send_item(mlr_pkg::ACT_START, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd0);
        send_step();
        send_step();
        // backwards
        send_item(mlr_pkg::ACT_START, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd5);
        // vertical up
        send_item(mlr_pkg::ACT_START, 16'sd0, -16'sd32768, 16'sd0, 16'sd32767);
        send_step();
        // vertical down
        send_item(mlr_pkg::ACT_START, -16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768);
        send_step();
        // same point
        send_item(mlr_pkg::ACT_START, 16'sd32767, 16'sd0, 16'sd32767, 16'sd0);
        // shallow down
        send_item(mlr_pkg::ACT_START, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32766);
        // steep up
        send_item(mlr_pkg::ACT_START, 16'sd0, 16'sd0, 16'sd1, 16'sd3);
        repeat (4) send_step();                                // last one is past the end
        // one-pixel vertical
        send_item(mlr_pkg::ACT_START, 16'sd5, 16'sd5, 16'sd5, 16'sd6);
        send_step();
        // steep down, cut short
        send_item(mlr_pkg::ACT_START, 16'sd0, 16'sd0, 16'sd2, -16'sd5);
        send_step();
        // restart mid-line
        send_item(mlr_pkg::ACT_START, 16'sd0, 16'sd0, 16'sd4, -16'sd1);
        repeat (4) send_step();
        // dy == -dx
        send_item(mlr_pkg::ACT_START, 16'sd0, 16'sd0, 16'sd3, -16'sd3);
        send_step();
        // horizontal
        send_item(mlr_pkg::ACT_START, 16'sd0, 16'sd0, 16'sd5, 16'sd0);

        // Random phases: idle mix flips, then runs flat out. Each phase ends
        // with the sender held off until every owed point has come back.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 31;
                    recv_idle_pct = 65;
                end
                1:
                begin
                    send_idle_pct = 65;
                    recv_idle_pct = 31;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target = fed_items + 583;
            while (fed_items < target) random_sequence();
            drain();
        end

        if (tracker.mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/mlr_pkg.sv
rtl/core/mlr_setup.sv
rtl/core/mlr_step.sv
rtl/core/midpoint_line_rasterizer.sv
test/tb.sv
